[rtl/sjmc_pkg.sv]
// ----------------------------------------------------------------------------
// sjmc_pkg: shared definitions for the synchronized joint move controller
// Widths, fixed-point constants, register codes, state encodings and the
// request/response structs that pass between the sequencer and its units.
// ----------------------------------------------------------------------------
`default_nettype none

package sjmc_pkg;

  localparam int JOINTS     = 6;
  localparam int JIDX_W     = $clog2(JOINTS);
  localparam int ANGLE_W    = 16;
  localparam int MAXV_W     = 13;
  localparam int TOL_W      = 12;
  localparam int TPR_W      = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int SPD_MAG_W  = MAXV_W;
  localparam int SPD_W      = SPD_MAG_W + 1;
  localparam int OUT_W      = 16;
  localparam int TICK_W     = 24;
  localparam int SUM_W      = SPD_MAG_W + $clog2(JOINTS);

  // Shared multiplier: angle magnitude by up to a 22-bit constant
  localparam int MUL_A_W    = ANGLE_W;
  localparam int MUL_B_W    = 22;
  localparam int MUL_P_W    = MUL_A_W + MUL_B_W;

  // Serial divider: quotient never exceeds max_velocity
  localparam int DIV_Q_W    = MAXV_W;
  localparam int DIV_D_W    = ANGLE_W;
  localparam int DIV_N_W    = DIV_D_W + DIV_Q_W;
  localparam int DIV_CNT_W  = $clog2(DIV_Q_W + 1);

  // Q12 rad/s to Q8.8 deg/s: multiply by 57.2957795 in Q16, drop 20 bits
  localparam int CONV_SHIFT = 20;
  localparam int CONV_Q_W   = OUT_W - 1;

  // Timeout compares ticks against the limit's Q20 integer part only
  localparam int LIM_SHIFT  = 20;
  localparam int LIM_W      = ANGLE_W + TPR_W - LIM_SHIFT;

  typedef logic signed [ANGLE_W-1:0] angle_t;
  typedef logic        [ANGLE_W-1:0] mag_t;
  typedef logic signed [SPD_W-1:0]   spd_t;

  localparam mag_t TWO_PI_Q12 = 16'd25736;
  localparam mag_t PI_Q12     = 16'd12868;
  localparam logic [MUL_B_W-1:0] DEG_PER_RAD_Q16 = 22'd3754937;
  localparam logic [MUL_P_W-1:0] CONV_HALF = MUL_P_W'(1) << (CONV_SHIFT - 1);
  // sum * 100 < 4096 holds exactly for sum <= 40
  localparam logic [SUM_W-1:0] SUM_STOP_MAX = SUM_W'(40);

  localparam logic [MAXV_W-1:0] MAXV_RST = 13'd1930;
  localparam logic [TOL_W-1:0]  TOL_RST  = 12'd145;
  localparam logic [TPR_W-1:0]  TPR_RST  = 16'd29336;
  localparam logic [JOINTS-1:0] CONT_RST = 6'd57;
  localparam logic [JOINTS-1:0] FLIP_RST = 6'd61;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAX_VELOCITY,
    CFG_TOLERANCE,
    CFG_TICKS_PER_RAD,
    CFG_CONT_MASK,
    CFG_FLIP_MASK
  } cfg_reg_t;

  typedef enum logic {
    CMD_TICK  = 1'b0,
    CMD_START = 1'b1
  } cmd_code_t;

  typedef enum logic [1:0] {
    MV_IDLE,
    MV_MOVING,
    MV_DONE,
    MV_TIMEOUT
  } move_status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_TGO,
    S_TWAIT,
    S_LIMIT,
    S_LIMIT_CAP,
    S_SMUL,
    S_DGO,
    S_DWAIT,
    S_EVAL,
    S_TIME,
    S_CONV,
    S_CONV_CAP,
    S_EMIT
  } sjmc_state_t;

  typedef enum logic [2:0] {
    TRV_IDLE,
    TRV_ABS,
    TRV_RED1,
    TRV_RED2,
    TRV_WRAP
  } trv_step_t;

  typedef struct packed {
    logic   start;
    logic   wrap;
    angle_t src_ang;
    angle_t dst_ang;
  } trv_req_t;

  typedef struct packed {
    logic done;
    logic neg;
    mag_t mag;
  } trv_rsp_t;

  typedef struct packed {
    logic               start;
    logic [DIV_N_W-1:0] dividend;
    logic [DIV_D_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [DIV_Q_W-1:0] quot;
  } div_rsp_t;

endpackage

`default_nettype wire

[rtl/sjmc_if.sv]
// ----------------------------------------------------------------------------
// sjmc_if: valid/ready channels of the joint move controller
// Command channel (tick or start with six angles) and result channel
// (six speeds, move status, growing mask).
// ----------------------------------------------------------------------------
`default_nettype none

interface sjmc_in_if;
  import sjmc_pkg::*;

  logic   valid;
  logic   ready;
  logic   command;
  angle_t angle_0;
  angle_t angle_1;
  angle_t angle_2;
  angle_t angle_3;
  angle_t angle_4;
  angle_t angle_5;

  modport source (
    output valid, command, angle_0, angle_1, angle_2, angle_3, angle_4, angle_5,
    input  ready
  );
  modport sink (
    input  valid, command, angle_0, angle_1, angle_2, angle_3, angle_4, angle_5,
    output ready
  );
endinterface

interface sjmc_out_if;
  import sjmc_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] speed_0;
  logic signed [OUT_W-1:0] speed_1;
  logic signed [OUT_W-1:0] speed_2;
  logic signed [OUT_W-1:0] speed_3;
  logic signed [OUT_W-1:0] speed_4;
  logic signed [OUT_W-1:0] speed_5;
  logic [1:0]              move_status;
  logic [JOINTS-1:0]       growing_mask;

  modport source (
    output valid, speed_0, speed_1, speed_2, speed_3, speed_4, speed_5,
           move_status, growing_mask,
    input  ready
  );
  modport sink (
    input  valid, speed_0, speed_1, speed_2, speed_3, speed_4, speed_5,
           move_status, growing_mask,
    output ready
  );
endinterface

`default_nettype wire

[rtl/sjmc_travel.sv]
// ----------------------------------------------------------------------------
// sjmc_travel: multi-cycle joint travel unit
// Forms target minus source, takes its magnitude and, for a wrapping joint,
// folds it into the shortest way round; each step is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module sjmc_travel (
  input  logic               clk,
  input  logic               rst_n,
  input  sjmc_pkg::trv_req_t req,
  output sjmc_pkg::trv_rsp_t rsp
);
  import sjmc_pkg::*;

  trv_step_t                step_r, step_nxt;
  logic                     done_r;
  logic signed [ANGLE_W:0]  d_r;
  logic signed [ANGLE_W:0]  d_abs;
  logic                     wrap_r;
  logic                     neg_r;
  mag_t                     m_r;
  logic                     fold;

  // next step
  always_comb begin
    step_nxt = step_r;
    unique case (step_r)
      TRV_IDLE: if (req.start) step_nxt = TRV_ABS;
      TRV_ABS:  step_nxt = TRV_RED1;
      TRV_RED1: step_nxt = TRV_RED2;
      TRV_RED2: step_nxt = TRV_WRAP;
      TRV_WRAP: step_nxt = TRV_IDLE;
      default:  step_nxt = TRV_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    rsp.done = done_r;
    rsp.neg  = neg_r;
    rsp.mag  = m_r;
  end

  assign d_abs = d_r[ANGLE_W] ? -d_r : d_r;
  // an exact half turn goes the negative way
  assign fold  = wrap_r && (neg_r ? (m_r > PI_Q12) : (m_r >= PI_Q12));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= TRV_IDLE;
      done_r <= 1'b0;
    end else begin
      step_r <= step_nxt;
      done_r <= (step_r == TRV_WRAP);
    end
  end

  always_ff @(posedge clk) begin
    case (step_r)
      TRV_IDLE: begin
        if (req.start) begin
          d_r    <= {req.dst_ang[ANGLE_W-1], req.dst_ang}
                    - {req.src_ang[ANGLE_W-1], req.src_ang};
          wrap_r <= req.wrap;
        end
      end
      TRV_ABS: begin
        neg_r <= d_r[ANGLE_W];
        m_r   <= d_abs[ANGLE_W-1:0];
      end
      TRV_RED1, TRV_RED2: begin
        // drop whole turns, sign kept aside
        if (wrap_r && (m_r >= TWO_PI_Q12)) m_r <= m_r - TWO_PI_Q12;
      end
      TRV_WRAP: begin
        if (fold) begin
          m_r   <= TWO_PI_Q12 - m_r;
          neg_r <= ~neg_r;
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

[rtl/sjmc_div.sv]
// ----------------------------------------------------------------------------
// sjmc_div: restoring serial divider
// One quotient bit per cycle; the dividend is known to give a quotient that
// fits the quotient width, so only that many steps run.
// ----------------------------------------------------------------------------
`default_nettype none

module sjmc_div (
  input  logic               clk,
  input  logic               rst_n,
  input  sjmc_pkg::div_req_t req,
  output sjmc_pkg::div_rsp_t rsp
);
  import sjmc_pkg::*;

  logic                 busy_r;
  logic                 done_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [DIV_D_W-1:0]   rem_r;
  logic [DIV_D_W-1:0]   dsr_r;
  logic [DIV_Q_W-1:0]   q_r;
  logic [DIV_D_W:0]     wide;
  logic [DIV_D_W+1:0]   diff;
  logic                 ge;

  // trial subtract of the shifted partial remainder
  always_comb begin
    wide = {rem_r, q_r[DIV_Q_W-1]};
    diff = {1'b0, wide} - {2'b00, dsr_r};
    ge   = ~diff[DIV_D_W+1];
  end

  assign rsp.done = done_r;
  assign rsp.quot = q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= DIV_CNT_W'(DIV_Q_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - DIV_CNT_W'(1);
        if (cnt_r == DIV_CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // quotient bits shift in as dividend bits shift out
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= req.dividend[DIV_N_W-1:DIV_Q_W];
      q_r   <= req.dividend[DIV_Q_W-1:0];
      dsr_r <= req.divisor;
    end else if (busy_r) begin
      rem_r <= ge ? diff[DIV_D_W-1:0] : wide[DIV_D_W-1:0];
      q_r   <= {q_r[DIV_Q_W-2:0], ge};
    end
  end

endmodule

`default_nettype wire

[rtl/synchronized_joint_move_controller.sv]
// ----------------------------------------------------------------------------
// synchronized_joint_move_controller: six-joint synchronized velocity move
// Plans per-joint speeds from measured and target angles, stops arrived
// joints on each tick, and reports done, timeout and growing distance.
// ----------------------------------------------------------------------------
//
//   channel   dir  handshake        transaction contents
//   in_chan   in   valid/ready      command (0 tick, 1 start), angle_0..5 Q3.12
//   out_chan  out  valid/ready      speed_0..5 Q8.8 deg/s, move_status, mask
//   cfg_*     in   cfg_we only      cfg_index selects register, cfg_data value
//
// A start transaction makes six passes through the travel unit, then, per
// moving joint, a multiply and a 13-step serial divide, then six output
// conversions. A tick while moving also makes six travel passes; a tick
// while idle makes none.
// in_chan.ready is high only while the sequencer idles; one finished result
// may wait in the output register while the next transaction is worked on.
// Reset is synchronous, active low, and restores the register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module synchronized_joint_move_controller (
  input  logic                               clk,
  input  logic                               rst_n,
  sjmc_in_if.sink                            in_chan,
  sjmc_out_if.source                         out_chan,
  input  logic                               cfg_we,
  input  logic [sjmc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [sjmc_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import sjmc_pkg::*;

  // sequencer
  sjmc_state_t             state_r, state_nxt;
  logic [JIDX_W-1:0]       j_r;
  logic                    last_j;
  logic                    in_acc;
  logic                    out_acc;
  logic                    out_free;

  // configuration registers
  logic [MAXV_W-1:0]       maxv_r;
  logic [TOL_W-1:0]        tol_r;
  logic [TPR_W-1:0]        tpr_r;
  logic [JOINTS-1:0]       cont_r;
  logic [JOINTS-1:0]       flip_r;

  // move state
  angle_t                  ang_in [JOINTS];
  angle_t                  meas_r [JOINTS];
  angle_t                  tgt_r  [JOINTS];
  spd_t                    spd_r  [JOINTS];
  mag_t                    lrem_r [JOINTS];
  mag_t                    rem_r  [JOINTS];
  logic [JOINTS-1:0]       sgn_r;
  mag_t                    longest_r;
  logic [SUM_W-1:0]        sum_r;
  logic [TICK_W-1:0]       tick_r;
  logic [LIM_W-1:0]        lim_r;
  logic                    moving_r;
  logic                    cmd_r;
  move_status_t            stat_r;
  logic [JOINTS-1:0]       grow_r;

  // result staging and output register
  logic signed [OUT_W-1:0] oconv_r [JOINTS];
  logic signed [OUT_W-1:0] ospd_r  [JOINTS];
  move_status_t            ostat_r;
  logic [JOINTS-1:0]       ogrow_r;
  logic                    out_valid_r;

  // shared multiplier
  logic [MUL_A_W-1:0]      mul_a;
  logic [MUL_B_W-1:0]      mul_b;
  logic [MUL_P_W-1:0]      mul_p_r;

  // per-joint datapath terms
  spd_t                    spd_cur;
  spd_t                    spd_neg_v;
  logic [SPD_MAG_W-1:0]    spd_abs;
  logic                    elig;
  logic                    stop_now;
  logic                    timeout;
  logic [JOINTS-1:0]       grow_v;
  logic [ANGLE_W:0]        grow_lim;
  spd_t                    q_s;
  spd_t                    spd_new;
  logic [MUL_P_W-1:0]      conv_rnd;
  logic [CONV_Q_W-1:0]     conv_q;
  logic signed [OUT_W-1:0] conv_mag;
  logic signed [OUT_W-1:0] conv_val;
  logic                    conv_neg;

  trv_req_t                trv_req;
  trv_rsp_t                trv_rsp;
  div_req_t                div_req;
  div_rsp_t                div_rsp;

  sjmc_travel u_travel (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (trv_req),
    .rsp   (trv_rsp)
  );

  sjmc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // ---------------------------------------------------------------- ports
  always_comb begin
    ang_in[0] = in_chan.angle_0;
    ang_in[1] = in_chan.angle_1;
    ang_in[2] = in_chan.angle_2;
    ang_in[3] = in_chan.angle_3;
    ang_in[4] = in_chan.angle_4;
    ang_in[5] = in_chan.angle_5;
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.speed_0      = ospd_r[0];
  assign out_chan.speed_1      = ospd_r[1];
  assign out_chan.speed_2      = ospd_r[2];
  assign out_chan.speed_3      = ospd_r[3];
  assign out_chan.speed_4      = ospd_r[4];
  assign out_chan.speed_5      = ospd_r[5];
  assign out_chan.move_status  = ostat_r;
  assign out_chan.growing_mask = ogrow_r;

  assign in_acc   = in_chan.valid && in_chan.ready;
  assign out_acc  = out_valid_r && out_chan.ready;
  assign out_free = !out_valid_r || out_chan.ready;
  assign last_j   = (j_r == JIDX_W'(JOINTS - 1));

  // ------------------------------------------------------- datapath terms
  always_comb begin
    spd_cur   = spd_r[j_r];
    spd_neg_v = -spd_cur;
    spd_abs   = spd_cur[SPD_W-1] ? spd_neg_v[SPD_MAG_W-1:0] : spd_cur[SPD_MAG_W-1:0];

    // a joint gets a scaled speed only if its travel is beyond tolerance
    elig      = (lrem_r[j_r] > mag_t'(tol_r)) && (longest_r != '0);

    // speed = sign * floor(|travel| * max_velocity / longest)
    q_s       = $signed({1'b0, div_rsp.quot});
    spd_new   = sgn_r[j_r] ? -q_s : q_s;

    // round half away from zero on the magnitude, then apply the sign
    conv_rnd  = mul_p_r + CONV_HALF;
    conv_q    = conv_rnd[CONV_SHIFT +: CONV_Q_W];
    conv_mag  = $signed({1'b0, conv_q});
    conv_neg  = spd_cur[SPD_W-1] ^ flip_r[j_r];
    conv_val  = conv_neg ? -conv_mag : conv_mag;

    stop_now  = (sum_r <= SUM_STOP_MAX);
    timeout   = (tick_r > TICK_W'(lim_r));

    // flag joints still driven whose distance grew past last + tolerance
    grow_v   = '0;
    grow_lim = '0;
    for (int k = 0; k < JOINTS; k++) begin
      grow_lim  = {1'b0, lrem_r[k]} + (ANGLE_W + 1)'(tol_r);
      grow_v[k] = ({1'b0, rem_r[k]} > grow_lim) && (spd_r[k] != '0);
    end
  end

  // ----------------------------------------------------------- next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if ((in_chan.command == CMD_START) || moving_r) state_nxt = S_TGO;
          else                                            state_nxt = S_EMIT;
        end
      end
      S_TGO:   state_nxt = S_TWAIT;
      S_TWAIT: begin
        if (trv_rsp.done) begin
          if (!last_j)    state_nxt = S_TGO;
          else if (cmd_r) state_nxt = S_LIMIT;
          else            state_nxt = S_EVAL;
        end
      end
      S_LIMIT:     state_nxt = S_LIMIT_CAP;
      S_LIMIT_CAP: state_nxt = S_SMUL;
      S_SMUL: begin
        if (elig)        state_nxt = S_DGO;
        else if (last_j) state_nxt = S_CONV;
      end
      S_DGO:   state_nxt = S_DWAIT;
      S_DWAIT: begin
        if (div_rsp.done) state_nxt = last_j ? S_CONV : S_SMUL;
      end
      S_EVAL:     state_nxt = stop_now ? S_EMIT : S_TIME;
      S_TIME:     state_nxt = timeout ? S_EMIT : S_CONV;
      S_CONV:     state_nxt = S_CONV_CAP;
      S_CONV_CAP: state_nxt = last_j ? S_EMIT : S_CONV;
      S_EMIT: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // --------------------------------------------------------------- outputs
  always_comb begin
    in_chan.ready    = (state_r == S_IDLE);

    trv_req.start    = (state_r == S_TGO);
    trv_req.wrap     = cont_r[j_r];
    trv_req.src_ang  = meas_r[j_r];
    trv_req.dst_ang  = tgt_r[j_r];

    div_req.start    = (state_r == S_DGO);
    div_req.dividend = mul_p_r[DIV_N_W-1:0];
    div_req.divisor  = longest_r;

    // steer the shared multiplier
    unique case (state_r)
      S_SMUL: begin
        mul_a = lrem_r[j_r];
        mul_b = MUL_B_W'(maxv_r);
      end
      S_LIMIT: begin
        mul_a = longest_r;
        mul_b = MUL_B_W'(tpr_r);
      end
      S_CONV: begin
        mul_a = MUL_A_W'(spd_abs);
        mul_b = DEG_PER_RAD_Q16;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // ------------------------------------------------ control and move state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      j_r         <= '0;
      maxv_r      <= MAXV_RST;
      tol_r       <= TOL_RST;
      tpr_r       <= TPR_RST;
      cont_r      <= CONT_RST;
      flip_r      <= FLIP_RST;
      tick_r      <= '0;
      lim_r       <= '0;
      moving_r    <= 1'b0;
      out_valid_r <= 1'b0;
      for (int k = 0; k < JOINTS; k++) begin
        meas_r[k] <= '0;
        tgt_r[k]  <= '0;
        spd_r[k]  <= '0;
        lrem_r[k] <= '0;
      end
    end else begin
      state_r <= state_nxt;

      // the user must write configuration only while no transaction is in flight; the block does not check it
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_MAX_VELOCITY:  maxv_r <= cfg_data[MAXV_W-1:0];
          CFG_TOLERANCE:     tol_r  <= cfg_data[TOL_W-1:0];
          CFG_TICKS_PER_RAD: tpr_r  <= cfg_data[TPR_W-1:0];
          CFG_CONT_MASK:     cont_r <= cfg_data[JOINTS-1:0];
          CFG_FLIP_MASK:     flip_r <= cfg_data[JOINTS-1:0];
          default: ;
        endcase
      end

      // load a fresh result, or drop the one just taken
      if ((state_r == S_EMIT) && out_free) out_valid_r <= 1'b1;
      else if (out_acc)                    out_valid_r <= 1'b0;

      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            j_r <= '0;
            if (in_chan.command == CMD_START) begin
              // start: record targets, restart the tick count
              for (int k = 0; k < JOINTS; k++) tgt_r[k] <= ang_in[k];
              moving_r <= 1'b1;
              tick_r   <= '0;
            end else begin
              for (int k = 0; k < JOINTS; k++) meas_r[k] <= ang_in[k];
            end
          end
        end
        S_TWAIT: begin
          if (trv_rsp.done) begin
            j_r <= last_j ? '0 : j_r + JIDX_W'(1);
            if (cmd_r) begin
              lrem_r[j_r] <= trv_rsp.mag;
            end else if (trv_rsp.mag < mag_t'(tol_r)) begin
              // arrived: stop this joint
              spd_r[j_r] <= '0;
            end
          end
        end
        S_LIMIT_CAP: begin
          lim_r <= mul_p_r[LIM_SHIFT +: LIM_W];
        end
        S_SMUL: begin
          if (!elig) begin
            spd_r[j_r] <= '0;
            j_r        <= last_j ? '0 : j_r + JIDX_W'(1);
          end
        end
        S_DWAIT: begin
          if (div_rsp.done) begin
            spd_r[j_r] <= spd_new;
            j_r        <= last_j ? '0 : j_r + JIDX_W'(1);
          end
        end
        S_EVAL: begin
          if (stop_now) begin
            moving_r <= 1'b0;
          end else begin
            // hold last_remaining for growing joints, advance the rest
            for (int k = 0; k < JOINTS; k++) begin
              if (!grow_v[k]) lrem_r[k] <= rem_r[k];
            end
            if (tick_r != '1) tick_r <= tick_r + TICK_W'(1);
          end
        end
        S_TIME: begin
          if (timeout) moving_r <= 1'b0;
        end
        S_CONV_CAP: begin
          j_r <= last_j ? '0 : j_r + JIDX_W'(1);
        end
        default: ;
      endcase
    end
  end

  // ------------------------------------------------------- payload registers
  always_ff @(posedge clk) begin
    mul_p_r <= MUL_P_W'(mul_a) * MUL_P_W'(mul_b);

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          cmd_r     <= (in_chan.command == CMD_START);
          longest_r <= '0;
          sum_r     <= '0;
          grow_r    <= '0;
          stat_r    <= (in_chan.command == CMD_START) ? MV_MOVING : MV_IDLE;
        end
      end
      S_TWAIT: begin
        if (trv_rsp.done) begin
          if (cmd_r) begin
            sgn_r[j_r] <= trv_rsp.neg;
            if (trv_rsp.mag > longest_r) longest_r <= trv_rsp.mag;
          end else begin
            rem_r[j_r] <= trv_rsp.mag;
            if (!(trv_rsp.mag < mag_t'(tol_r))) sum_r <= sum_r + SUM_W'(spd_abs);
          end
        end
      end
      S_EVAL: begin
        if (stop_now) begin
          stat_r <= MV_DONE;
          grow_r <= '0;
        end else begin
          grow_r <= grow_v;
        end
      end
      S_TIME: begin
        stat_r <= timeout ? MV_TIMEOUT : MV_MOVING;
      end
      S_CONV_CAP: begin
        oconv_r[j_r] <= conv_val;
      end
      S_EMIT: begin
        if (out_free) begin
          // speeds go out only with a moving status
          for (int k = 0; k < JOINTS; k++) begin
            ospd_r[k] <= (stat_r == MV_MOVING) ? oconv_r[k] : '0;
          end
          ostat_r <= stat_r;
          ogrow_r <= grow_r;
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

[dv/synchronized_joint_move_controller_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// synchronized_joint_move_controller_test: self-checking bench for the
// six-joint synchronized move controller
// Drives tick and start transactions over the command channel. A local
// predictor plans and tracks each move and checks every result transaction
// field by field. A short table of directed transactions comes first, then
// randomized move sequences under several register settings and flow-control
// mixes.
// ----------------------------------------------------------------------------

module synchronized_joint_move_controller_test;
  import sjmc_pkg::*;

  localparam int     HALF_PERIOD     = 5;
  localparam int     RESET_CYCLES    = 8;
  localparam int     SETTLE_CYCLES   = 200;       // longer than a start transaction
  localparam int     ITEMS_PER_PHASE = 250;
  localparam int     PHASES          = 6;
  localparam int     REPORT_LIMIT    = 10;
  localparam longint RUN_LIMIT_NS    = 50_000_000;

  localparam longint TURN_Q12  = longint'(TWO_PI_Q12);
  localparam longint HALF_Q12  = longint'(PI_Q12);
  localparam longint DEG_Q16   = longint'(DEG_PER_RAD_Q16);
  localparam longint TICK_CAP  = (longint'(1) << TICK_W) - 1;
  localparam longint LIMIT_CAP = 64'hFFFF_FFFF;

  // no register lives at this index; a write to it must change nothing
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = CFG_IDX_W'(7);

  localparam logic PINNED    = 1'b1;
  localparam logic PREDICTED = 1'b0;

  typedef struct packed {
    cmd_code_t                      cmd;
    logic [JOINTS-1:0][ANGLE_W-1:0] ang;
  } joint_cmd_t;

  typedef struct packed {
    logic [JOINTS-1:0][OUT_W-1:0] spd;
    move_status_t                 status;
    logic [JOINTS-1:0]            grow;
  } joint_result_t;

  // Directed rows; a pinned row carries its status, with speeds and mask zero
  typedef struct packed {
    joint_cmd_t   item;
    logic         pinned;
    move_status_t st;
  } stim_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  sjmc_in_if  in_chan ();
  sjmc_out_if out_chan ();

  synchronized_joint_move_controller dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #(HALF_PERIOD) clk = ~clk;

  // --------------------------------------------------------------------------
  // Predictor state: register copies and the move being tracked
  // --------------------------------------------------------------------------
  logic [MAXV_W-1:0] cfg_max_vel = MAXV_RST;
  logic [TOL_W-1:0]  cfg_tol     = TOL_RST;
  logic [TPR_W-1:0]  cfg_tpr     = TPR_RST;
  logic [JOINTS-1:0] cfg_wrap    = CONT_RST;
  logic [JOINTS-1:0] cfg_flip    = FLIP_RST;

  longint meas_q12[JOINTS]   = '{default: 0};
  longint target_q12[JOINTS] = '{default: 0};
  longint speed_q12[JOINTS]  = '{default: 0};
  longint last_dist[JOINTS]  = '{default: 0};
  longint tick_cnt           = 0;
  longint tick_limit_q20     = 0;
  bit     in_move            = 1'b0;

  joint_result_t speed_reports_due[$];

  int gap_pct    = 0;
  int stall_pct  = 0;
  int items_sent = 0;
  int mismatches = 0;
  int results_seen = 0;

  function automatic longint dist_mag(longint v);
    return (v < 0) ? -v : v;
  endfunction

  // Signed travel; wrapping joints take the shortest way, half turn negative
  function automatic longint joint_travel(int j, longint from_a, longint to_a);
    longint d;
    d = to_a - from_a;
    if (cfg_wrap[j]) begin
      d = d % TURN_Q12;
      if (d >= HALF_Q12) begin
        d = d - TURN_Q12;
      end else if (d < -HALF_Q12) begin
        d = d + TURN_Q12;
      end
    end
    return d;
  endfunction

  // Q12 rad/s to Q8.8 deg/s, round half away from zero, flip, saturate
  function automatic logic [OUT_W-1:0] to_deg_q8_8(int j, longint s);
    longint p, q, v;
    p = s * DEG_Q16;
    q = (dist_mag(p) + (longint'(1) << (CONV_SHIFT - 1))) >>> CONV_SHIFT;
    if (q > 65536) q = 65536;
    v = (p < 0) ? -q : q;
    if (cfg_flip[j]) v = -v;
    if (v > 32767) begin
      v = 32767;
    end else if (v < -32768) begin
      v = -32768;
    end
    return OUT_W'(v);
  endfunction

  // Plan on a start, track on a tick; returns the report the block owes
  function automatic joint_result_t track_move(joint_cmd_t c);
    joint_result_t r;
    longint ang[JOINTS];
    longint trv[JOINTS];
    longint rem[JOINTS];
    longint longest, m, v, sum, tol_l, maxv_l;
    r = '0;
    tol_l  = longint'(cfg_tol);
    maxv_l = longint'(cfg_max_vel);
    for (int j = 0; j < JOINTS; j++) ang[j] = $signed(c.ang[j]);

    if (c.cmd == CMD_START) begin
      longest = 0;
      for (int j = 0; j < JOINTS; j++) begin
        target_q12[j] = ang[j];
        trv[j] = joint_travel(j, meas_q12[j], ang[j]);
        if (dist_mag(trv[j]) > longest) longest = dist_mag(trv[j]);
      end
      for (int j = 0; j < JOINTS; j++) begin
        m = dist_mag(trv[j]);
        last_dist[j] = m;
        if (m > tol_l && longest != 0) begin
          v = (m * maxv_l) / longest;
          speed_q12[j] = (trv[j] < 0) ? -v : v;
        end else begin
          speed_q12[j] = 0;
        end
      end
      tick_limit_q20 = longest * longint'(cfg_tpr);
      if (tick_limit_q20 > LIMIT_CAP) tick_limit_q20 = LIMIT_CAP;
      tick_cnt = 0;
      in_move  = 1'b1;
      for (int j = 0; j < JOINTS; j++) r.spd[j] = to_deg_q8_8(j, speed_q12[j]);
      r.status = MV_MOVING;
      return r;
    end

    for (int j = 0; j < JOINTS; j++) meas_q12[j] = ang[j];
    if (!in_move) begin
      r.status = MV_IDLE;
      return r;
    end

    // stop arrived joints; a near-zero speed sum ends the move
    sum = 0;
    for (int j = 0; j < JOINTS; j++) begin
      rem[j] = dist_mag(joint_travel(j, ang[j], target_q12[j]));
      if (rem[j] < tol_l) speed_q12[j] = 0;
      sum += dist_mag(speed_q12[j]);
    end
    if (sum * 100 < 4096) begin
      in_move  = 1'b0;
      r.status = MV_DONE;
      return r;
    end

    // flag growth; a flagged joint keeps its old distance
    for (int j = 0; j < JOINTS; j++) begin
      if (rem[j] > last_dist[j] + tol_l && speed_q12[j] != 0) begin
        r.grow[j] = 1'b1;
      end else begin
        last_dist[j] = rem[j];
      end
    end
    if (tick_cnt < TICK_CAP) tick_cnt++;
    if ((tick_cnt << LIM_SHIFT) > tick_limit_q20) begin
      in_move  = 1'b0;
      r.status = MV_TIMEOUT;
      return r;
    end
    for (int j = 0; j < JOINTS; j++) r.spd[j] = to_deg_q8_8(j, speed_q12[j]);
    r.status = MV_MOVING;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic int jitter(int span);
    return int'($urandom_range(2 * span)) - span;
  endfunction

  function automatic stim_row_t row(logic pinned, move_status_t st, cmd_code_t k,
                                    int a0, int a1, int a2, int a3, int a4, int a5);
    stim_row_t s;
    s.pinned     = pinned;
    s.st         = st;
    s.item.cmd   = k;
    s.item.ang[0] = ANGLE_W'(a0);
    s.item.ang[1] = ANGLE_W'(a1);
    s.item.ang[2] = ANGLE_W'(a2);
    s.item.ang[3] = ANGLE_W'(a3);
    s.item.ang[4] = ANGLE_W'(a4);
    s.item.ang[5] = ANGLE_W'(a5);
    return s;
  endfunction

  // Present one transaction, hold it until accepted, then log what it owes.
  // Valid stays high into the next call unless that call idles first.
  task automatic send_cmd(joint_cmd_t c, logic pinned, joint_result_t want);
    int gap;
    joint_result_t owed;
    gap = 0;
    while ($urandom_range(99) < gap_pct) gap++;
    // an occasional long pause lands the next transaction on any cycle of the work
    if (gap_pct != 0 && $urandom_range(7) == 0) gap += $urandom_range(160);
    if (gap != 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid   <= 1'b1;
    in_chan.command <= c.cmd;
    in_chan.angle_0 <= c.ang[0];
    in_chan.angle_1 <= c.ang[1];
    in_chan.angle_2 <= c.ang[2];
    in_chan.angle_3 <= c.ang[3];
    in_chan.angle_4 <= c.ang[4];
    in_chan.angle_5 <= c.ang[5];
    do @(posedge clk); while (in_chan.ready !== 1'b1);
    owed = track_move(c);
    speed_reports_due.push_back(pinned ? want : owed);
    items_sent++;
  endtask

  // Drop valid and wait until every report is back and the block is quiet
  task automatic wait_drained();
    in_chan.valid <= 1'b0;
    while (speed_reports_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Hold cfg_we high across back-to-back writes; the caller lowers it
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int value, int w);
    logic [CFG_DATA_W-1:0] data;
    // junk above the register width must be ignored
    data = CFG_DATA_W'(value) | (CFG_DATA_W'($urandom) << w);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    case (idx)
      CFG_MAX_VELOCITY:  cfg_max_vel = data[MAXV_W-1:0];
      CFG_TOLERANCE:     cfg_tol     = data[TOL_W-1:0];
      CFG_TICKS_PER_RAD: cfg_tpr     = data[TPR_W-1:0];
      CFG_CONT_MASK:     cfg_wrap    = data[JOINTS-1:0];
      CFG_FLIP_MASK:     cfg_flip    = data[JOINTS-1:0];
      default: ;
    endcase
  endtask

  task automatic program_regs(int mv, int tl, int tp, int wr, int fl);
    write_reg(CFG_MAX_VELOCITY, mv, MAXV_W);
    write_reg(CFG_TOLERANCE, tl, TOL_W);
    write_reg(CFG_TICKS_PER_RAD, tp, TPR_W);
    write_reg(CFG_CONT_MASK, wr, JOINTS);
    write_reg(CFG_FLIP_MASK, fl, JOINTS);
    write_reg(CFG_SPARE_IDX, 0, 0);
    cfg_we <= 1'b0;
  endtask

  // Finish any open move by reporting every joint at its target
  task automatic park_move();
    joint_cmd_t c;
    c.cmd = CMD_TICK;
    while (in_move) begin
      for (int j = 0; j < JOINTS; j++) c.ang[j] = ANGLE_W'(target_q12[j]);
      send_cmd(c, PREDICTED, '0);
    end
  endtask

  // One start followed by a run of ticks that mostly close in on the target,
  // with arrivals, overshoots that grow the distance, and wild readings mixed in
  task automatic run_move();
    joint_cmd_t c;
    longint p, t;
    int ticks_left, k, tol_i;
    tol_i = int'(cfg_tol);
    c.cmd = CMD_START;
    for (int j = 0; j < JOINTS; j++) begin
      case ($urandom_range(3))
        0:       c.ang[j] = ANGLE_W'($urandom);
        1:       c.ang[j] = ANGLE_W'(meas_q12[j] + jitter(600));
        2:       c.ang[j] = ANGLE_W'(meas_q12[j] + jitter(8000));
        default: c.ang[j] = ANGLE_W'(meas_q12[j]);
      endcase
    end
    send_cmd(c, PREDICTED, '0);

    ticks_left = $urandom_range(1, 40);
    c.cmd = CMD_TICK;
    while (in_move && ticks_left > 0) begin
      for (int j = 0; j < JOINTS; j++) begin
        p = meas_q12[j];
        t = target_q12[j];
        k = $urandom_range(1, 4);
        case ($urandom_range(9))
          0:       p = t + jitter(tol_i);
          1:       p = p - (t - p) / 2 + jitter(50);
          2:       p = $urandom_range(65535);
          3:       ;
          default: p = p + ((t - p) * k) / 8 + jitter(20);
        endcase
        c.ang[j] = ANGLE_W'(p);
      end
      send_cmd(c, PREDICTED, '0);
      ticks_left--;
    end
  endtask

  // --------------------------------------------------------------------------
  // Result side: random back-pressure and the field-by-field check
  // --------------------------------------------------------------------------
  task automatic note_mismatch(string what, logic [OUT_W-1:0] want, logic [OUT_W-1:0] got);
    mismatches++;
    if (mismatches <= REPORT_LIMIT) begin
      $display("[%0t] result %0d %s: expected 0x%h, got 0x%h",
               $time, results_seen, what, want, got);
    end
  endtask

  initial begin : result_sink
    joint_result_t want, got;
    out_chan.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n === 1'b1 && out_chan.valid === 1'b1 && out_chan.ready === 1'b1) begin
        got.spd[0] = out_chan.speed_0;
        got.spd[1] = out_chan.speed_1;
        got.spd[2] = out_chan.speed_2;
        got.spd[3] = out_chan.speed_3;
        got.spd[4] = out_chan.speed_4;
        got.spd[5] = out_chan.speed_5;
        got.status = move_status_t'(out_chan.move_status);
        got.grow   = out_chan.growing_mask;
        if (speed_reports_due.size() == 0) begin
          note_mismatch("arrived with nothing outstanding", '0, '0);
        end else begin
          want = speed_reports_due.pop_front();
          for (int j = 0; j < JOINTS; j++) begin
            if (got.spd[j] !== want.spd[j]) begin
              note_mismatch($sformatf("speed_%0d", j), want.spd[j], got.spd[j]);
            end
          end
          if (got.status !== want.status) begin
            note_mismatch("move_status", OUT_W'(want.status), OUT_W'(got.status));
          end
          if (got.grow !== want.grow) begin
            note_mismatch("growing_mask", OUT_W'(want.grow), OUT_W'(got.grow));
          end
        end
        results_seen++;
      end
      out_chan.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    stim_row_t   plan[$];
    joint_cmd_t  c;
    joint_result_t want;
    int gap_plan[PHASES];
    int stall_plan[PHASES];
    int goal;

    // gap/stall mix per random phase: none, sender, receiver, both light, ...
    gap_plan   = '{0, 66, 0, 7, 66, 0};
    stall_plan = '{0, 0, 66, 7, 0, 66};

    rst_n           <= 1'b0;
    cfg_we          <= 1'b0;
    cfg_index       <= '0;
    cfg_data        <= '0;
    in_chan.valid   <= 1'b0;
    in_chan.command <= CMD_TICK;
    in_chan.angle_0 <= '0;
    in_chan.angle_1 <= '0;
    in_chan.angle_2 <= '0;
    in_chan.angle_3 <= '0;
    in_chan.angle_4 <= '0;
    in_chan.angle_5 <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Directed table, reset register values. Wrapping joints are 0, 3, 4, 5;
    // joints 1 and 2 are limited.
    // idle ticks report nothing, extremes included
    plan.push_back(row(PINNED, MV_IDLE, CMD_TICK, 0, 0, 0, 0, 0, 0));
    plan.push_back(row(PINNED, MV_IDLE, CMD_TICK, -32768, 32767, -32768, 32767, -1, 1));
    plan.push_back(row(PINNED, MV_IDLE, CMD_TICK, 0, 0, 0, 0, 0, 0));
    // zero travel everywhere: no division, all speeds zero, then done at once
    plan.push_back(row(PINNED, MV_MOVING, CMD_START, 0, 0, 0, 0, 0, 0));
    plan.push_back(row(PINNED, MV_DONE, CMD_TICK, 0, 0, 0, 0, 0, 0));
    // full positive travel on a limited joint
    plan.push_back(row(PREDICTED, MV_MOVING, CMD_START, 0, 32767, 0, 0, 0, 0));
    // start during a move replaces it; exact half turns both ways, wraps past a turn
    plan.push_back(row(PREDICTED, MV_MOVING, CMD_START,
                       12868, -32768, 32767, -12868, 25836, 32767));
    plan.push_back(row(PREDICTED, MV_MOVING, CMD_TICK, 100, -1000, 1000, -100, 10, 500));
    // joint 1 backs away: its distance grows past tolerance
    plan.push_back(row(PREDICTED, MV_MOVING, CMD_TICK, 100, 2000, 1000, -100, 10, 500));
    plan.push_back(row(PINNED, MV_DONE, CMD_TICK,
                       12868, -32768, 32767, -12868, 25836, 32767));
    plan.push_back(row(PINNED, MV_IDLE, CMD_TICK, 0, 0, 0, 0, 0, 0));
    // short travel: limit 200 * 29336, passed on the sixth tick
    plan.push_back(row(PREDICTED, MV_MOVING, CMD_START, 0, 200, 0, 0, 0, 0));
    repeat (5) plan.push_back(row(PREDICTED, MV_MOVING, CMD_TICK, 0, 0, 0, 0, 0, 0));
    plan.push_back(row(PINNED, MV_TIMEOUT, CMD_TICK, 0, 0, 0, 0, 0, 0));
    // travel equal to tolerance gets no speed; one above does
    plan.push_back(row(PREDICTED, MV_MOVING, CMD_START, 0, 145, 146, 0, 0, 0));
    plan.push_back(row(PREDICTED, MV_MOVING, CMD_TICK, 0, 0, 1, 0, 0, 0));
    plan.push_back(row(PINNED, MV_DONE, CMD_TICK, 0, 0, 2, 0, 0, 0));
    // wrap from below and above the half turn
    plan.push_back(row(PREDICTED, MV_MOVING, CMD_START,
                       -20000, 20000, -20000, 20000, 12868, -12868));
    plan.push_back(row(PREDICTED, MV_MOVING, CMD_TICK,
                       5000, 10000, -10000, 10000, 6000, -6000));
    plan.push_back(row(PINNED, MV_DONE, CMD_TICK,
                       -20000, 20000, -20000, 20000, 12868, -12868));

    foreach (plan[i]) begin
      want = '0;
      want.status = plan[i].st;
      send_cmd(plan[i].item, plan[i].pinned, want);
    end

    // Random phases, each under its own register setting and flow-control mix
    for (int ph = 0; ph < PHASES; ph++) begin
      park_move();
      wait_drained();
      case (ph)
        0: program_regs(MAXV_RST, TOL_RST, TPR_RST, CONT_RST, FLIP_RST);
        1: program_regs(0, 0, 0, 0, 0);
        2: program_regs(8191, 4095, 65535, 63, 63);
        3: program_regs($urandom_range(8191), $urandom_range(1, 4095),
                        $urandom_range(65535), $urandom_range(63), $urandom_range(63));
        default: program_regs($urandom_range(8191), $urandom_range(1, 600),
                              $urandom_range(65535), $urandom_range(63),
                              $urandom_range(63));
      endcase
      gap_pct   = gap_plan[ph];
      stall_pct = stall_plan[ph];

      goal = items_sent + ITEMS_PER_PHASE;
      while (items_sent < goal) begin
        if ($urandom_range(99) < 15) begin
          // noise: any command with arbitrary angles
          c.cmd = ($urandom_range(1) == 1) ? CMD_START : CMD_TICK;
          for (int j = 0; j < JOINTS; j++) c.ang[j] = ANGLE_W'($urandom);
          send_cmd(c, PREDICTED, '0);
        end else begin
          run_move();
        end
      end
    end

    park_move();
    wait_drained();
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Hard stop well beyond the slowest legal run
  initial begin : watchdog
    #(RUN_LIMIT_NS);
    $display("end of test: mismatches");
    $finish;
  end

endmodule
